>>> hw/rtl/ssr_pkg.sv
package ssr_pkg;

  localparam int WindowBytesDef = 8;
  localparam int ReplBytesDef   = 8;

  typedef enum logic [1:0] {
    CFG_PATTERN_BYTES  = 2'd0,
    CFG_PATTERN_LENGTH = 2'd1,
    CFG_REPL_BYTES     = 2'd2,
    CFG_REPL_LENGTH    = 2'd3
  } cfg_idx_t;

  // attributes shared by every result of one burst
  typedef struct packed {
    logic byte_valid;
    logic end_of_stream;
  } ssr_flags_t;

endpackage

>>> hw/rtl/stream_substring_replace_top.sv
// The first result of an input item is registered and appears in the cycle after that item is taken.
// Throughput: one input item per cycle while each item makes at most one result and
// out_stall is low; an item that makes several results holds the input while the burst
// register drains one result per cycle whenever out_stall is low.
// Reset (rst_n low, synchronous): window empty, no pending results, pattern
// length 1, replacement length 0, pattern and replacement bytes zero.
module stream_substring_replace_top #(
  parameter int WINDOW_BYTES      = ssr_pkg::WindowBytesDef,
  parameter int REPLACEMENT_BYTES = ssr_pkg::ReplBytesDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  input  logic        in_end_of_input,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        out_byte_valid,
  output logic        out_end_of_stream,
  output logic        out_last_of_run,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_wdata
);

  localparam int W  = WINDOW_BYTES;
  localparam int BN = (WINDOW_BYTES > REPLACEMENT_BYTES) ? WINDOW_BYTES : REPLACEMENT_BYTES;
  localparam int FW = $clog2(W + 1);
  localparam int CW = $clog2(BN + 1);

  logic [63:0] pattern_r;
  logic [3:0]  plen_r;
  logic [63:0] repl_r;
  logic [3:0]  rlen_r;

  logic [7:0]    win_r   [W];
  logic [7:0]    win_nxt [W];
  logic [FW-1:0] fill_r;
  logic [FW-1:0] fill_nxt;

  logic [7:0]          burst [BN];
  logic [CW-1:0]       burst_cnt;
  ssr_pkg::ssr_flags_t burst_flags;
  logic                ready;
  logic                accept;

  assign in_stall = !ready;
  assign accept   = in_valid && ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_r <= '0;
      plen_r    <= 4'd1;
      repl_r    <= '0;
      rlen_r    <= '0;
    end else if (cfg_we) begin
      unique case (ssr_pkg::cfg_idx_t'(cfg_index))
        ssr_pkg::CFG_PATTERN_BYTES:  pattern_r <= cfg_wdata;
        ssr_pkg::CFG_PATTERN_LENGTH: plen_r    <= cfg_wdata[3:0];
        ssr_pkg::CFG_REPL_BYTES:     repl_r    <= cfg_wdata;
        ssr_pkg::CFG_REPL_LENGTH:    rlen_r    <= cfg_wdata[3:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else if (accept) begin
      fill_r <= fill_nxt;
    end
  end

  // window entries at or above the fill count are never read
  always_ff @(posedge clk) begin
    if (accept) begin
      win_r <= win_nxt;
    end
  end

  ssr_step #(
    .W  (W),
    .RB (REPLACEMENT_BYTES),
    .BN (BN)
  ) u_step (
    .win_i     (win_r),
    .fill_i    (fill_r),
    .byte_i    (in_byte),
    .end_i     (in_end_of_input),
    .pattern_i (pattern_r),
    .plen_i    (plen_r),
    .repl_i    (repl_r),
    .rlen_i    (rlen_r),
    .win_o     (win_nxt),
    .fill_o    (fill_nxt),
    .burst_o   (burst),
    .cnt_o     (burst_cnt),
    .flags_o   (burst_flags)
  );

  ssr_burst #(
    .BN (BN)
  ) u_burst (
    .clk               (clk),
    .rst_n             (rst_n),
    .load_i            (accept),
    .burst_i           (burst),
    .cnt_i             (burst_cnt),
    .flags_i           (burst_flags),
    .ready_o           (ready),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_byte          (out_byte),
    .out_byte_valid    (out_byte_valid),
    .out_end_of_stream (out_end_of_stream),
    .out_last_of_run   (out_last_of_run)
  );

`ifndef SYNTH
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FW'(W))
    else $error("window fill above window size");

  a_stall_pending: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled with no pending result");

  a_end_flush: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_end_of_input) |=> (fill_r == '0))
    else $error("window not flushed after end of input");

  a_bare_marker: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_byte_valid) |-> (out_end_of_stream && out_last_of_run))
    else $error("bare marker is not the final result");
`endif

endmodule

>>> hw/rtl/ssr_step.sv
module ssr_step #(
  parameter int W  = ssr_pkg::WindowBytesDef,
  parameter int RB = ssr_pkg::ReplBytesDef,
  parameter int BN = ssr_pkg::WindowBytesDef,
  localparam int FW = $clog2(W + 1),
  localparam int CW = $clog2(BN + 1)
) (
  input  logic [7:0]         win_i [W],
  input  logic [FW-1:0]      fill_i,
  input  logic [7:0]         byte_i,
  input  logic               end_i,
  input  logic [63:0]        pattern_i,
  input  logic [3:0]         plen_i,
  input  logic [63:0]        repl_i,
  input  logic [3:0]         rlen_i,
  output logic [7:0]         win_o [W],
  output logic [FW-1:0]      fill_o,
  output logic [7:0]         burst_o [BN],
  output logic [CW-1:0]      cnt_o,
  output ssr_pkg::ssr_flags_t flags_o
);

  logic [FW-1:0] plen_eff;
  logic [CW-1:0] rlen_eff;
  logic [FW-1:0] fill0;
  logic [FW-1:0] fill1;
  logic [7:0]    wpush  [W];
  logic [7:0]    wshift [W];
  logic [7:0]    wpad   [BN];
  logic [7:0]    rpad   [BN];
  logic          match;
  logic          at_len;
  logic          over;
  logic          hit;

  assign plen_eff = (plen_i == 4'd0)    ? FW'(1) :
                    (plen_i > 4'(W))    ? FW'(W) : plen_i[FW-1:0];
  assign rlen_eff = (rlen_i > 4'(RB))   ? CW'(RB) : CW'(rlen_i);

  // a full window has always been drained by one before the next push
  assign fill0 = (fill_i >= FW'(W)) ? FW'(W - 1) : fill_i;
  assign fill1 = fill0 + FW'(1);

  always_comb begin
    for (int i = 0; i < W; i++) begin
      wpush[i] = (FW'(i) == fill0) ? byte_i : win_i[i];
    end
  end

  for (genvar g = 0; g < W; g++) begin : g_shift
    if (g + 1 < W) begin : g_mid
      assign wshift[g] = wpush[g+1];
    end else begin : g_top
      assign wshift[g] = wpush[g];
    end
  end

  for (genvar g = 0; g < BN; g++) begin : g_pad
    if (g < W) begin : g_win
      assign wpad[g] = wpush[g];
    end else begin : g_nowin
      assign wpad[g] = '0;
    end
    assign rpad[g] = repl_i[8*g +: 8];
  end

  always_comb begin
    match = 1'b1;
    for (int i = 0; i < W; i++) begin
      if (FW'(i) < plen_eff && wpush[i] != pattern_i[8*i +: 8]) begin
        match = 1'b0;
      end
    end
  end

  assign at_len = (fill1 == plen_eff);
  assign over   = (fill1 > plen_eff);
  assign hit    = at_len && match;

  always_comb begin
    win_o   = wpush;
    fill_o  = fill1;
    burst_o = wpad;
    cnt_o   = '0;
    flags_o = '{byte_valid: 1'b1, end_of_stream: 1'b0};

    if (hit) begin
      fill_o  = '0;
      burst_o = rpad;
      cnt_o   = rlen_eff;
    end else if (at_len || over) begin
      win_o  = wshift;
      fill_o = fill1 - FW'(1);
      cnt_o  = CW'(1);
    end

    if (end_i) begin
      fill_o = '0;
      flags_o.end_of_stream = 1'b1;
      if (hit) begin
        if (rlen_eff == '0) begin
          // match with empty replacement: lone end marker
          cnt_o              = CW'(1);
          flags_o.byte_valid = 1'b0;
          for (int i = 0; i < BN; i++) begin
            burst_o[i] = '0;
          end
        end
      end else begin
        // oldest byte (if dropped) plus the rest of the window, in order
        burst_o = wpad;
        cnt_o   = CW'(fill1);
      end
    end
  end

endmodule

>>> hw/rtl/ssr_burst.sv
module ssr_burst #(
  parameter int BN = ssr_pkg::WindowBytesDef,
  localparam int CW = $clog2(BN + 1)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load_i,
  input  logic [7:0]          burst_i [BN],
  input  logic [CW-1:0]       cnt_i,
  input  ssr_pkg::ssr_flags_t flags_i,
  output logic                ready_o,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [7:0]          out_byte,
  output logic                out_byte_valid,
  output logic                out_end_of_stream,
  output logic                out_last_of_run
);

  logic [7:0]          buf_r [BN];
  logic [CW-1:0]       cnt_r;
  ssr_pkg::ssr_flags_t flags_r;
  logic                pop;
  logic                last;

  assign out_valid = (cnt_r != '0);
  assign pop       = out_valid && !out_stall;
  assign last      = (cnt_r == CW'(1));
  // take a new burst once the current one is gone or leaves this cycle
  assign ready_o   = (cnt_r == '0) || (last && !out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (load_i) begin
      cnt_r <= cnt_i;
    end else if (pop) begin
      cnt_r <= cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load_i) begin
      buf_r   <= burst_i;
      flags_r <= flags_i;
    end else if (pop) begin
      for (int i = 0; i < BN - 1; i++) begin
        buf_r[i] <= buf_r[i+1];
      end
    end
  end

  assign out_byte          = buf_r[0];
  assign out_byte_valid    = flags_r.byte_valid;
  assign out_end_of_stream = flags_r.end_of_stream && last;
  assign out_last_of_run   = last;

endmodule
